>>> design/vca_pkg.sv
// voice channel allocator package: channel count, kind codes, controller states
// and the structs that pass between the controller and the channel cells
// no dependencies

package vca_pkg;

    // number of synth channels, one cell each (1..16)
    localparam int VCA_CHANNELS = 16;
    // channel index width, fixed by the result field
    localparam int VCA_CH_W     = 4;

    // input kind codes
    localparam logic [1:0] KIND_ON   = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_CUT  = 2'd2;

    // result action codes
    localparam logic ACT_OFF = 1'b0;
    localparam logic ACT_ON  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_STEAL,
        ST_STRIKE
    } t_state;

    // candidate token handed from cell to cell during a scan
    typedef struct packed {
        logic                live;
        logic                found;
        logic                free;
        logic [VCA_CH_W-1:0] idx;
        logic [31:0]         age;
        logic [6:0]          key;
    } t_cand;

    // command broadcast to every cell for the current scan
    typedef struct packed {
        logic        on;
        logic        by_id;
        logic [31:0] id;
        logic [15:0] src;
    } t_cmd;

    // channel write for a note-on
    typedef struct packed {
        logic                en;
        logic [VCA_CH_W-1:0] idx;
        logic [31:0]         id;
        logic [15:0]         src;
        logic [6:0]          key;
        logic [31:0]         age;
    } t_wr;

endpackage

>>> design/vca_cell.sv
// one synth channel cell: holds the channel state, updates the passing
// candidate token and flags release matches
// depends on vca_pkg

module vca_cell import vca_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VCA_CH_W-1:0] i_idx,
    input  logic                i_adv,
    input  t_cmd                i_cmd,
    input  t_cand               i_tok,
    input  t_wr                 i_wr,
    output t_cand               o_tok,
    output logic                o_hit,
    output logic [6:0]          o_key
);

    logic        r_held;
    logic [31:0] r_id;
    logic [15:0] r_src;
    logic [6:0]  r_key;
    logic [31:0] r_age;
    t_cand       r_tok;
    t_cand       n_tok;
    logic        w_match;
    logic        w_hit;
    logic        w_better;

    // release match against the broadcast command
    assign w_match = r_held && (r_src == i_cmd.src) && (!i_cmd.by_id || (r_id == i_cmd.id));
    assign w_hit   = i_tok.live && !i_cmd.on && w_match;

    // free beats held, then older start age, ties keep the earlier channel
    assign w_better = !i_tok.found
                   || (!r_held && !i_tok.free)
                   || (((!r_held) == i_tok.free) && (r_age < i_tok.age));

    // candidate update
    always_comb begin
        n_tok = i_tok;
        if (i_tok.live && i_cmd.on && w_better) begin
            n_tok.found = 1'b1;
            n_tok.free  = !r_held;
            n_tok.idx   = i_idx;
            n_tok.age   = r_age;
            n_tok.key   = r_key;
        end
    end

    // token register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_id   <= '0;
            r_src  <= '0;
            r_key  <= '0;
            r_age  <= '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_held <= 1'b1;
            r_id   <= i_wr.id;
            r_src  <= i_wr.src;
            r_key  <= i_wr.key;
            r_age  <= i_wr.age;
        end else if (i_adv && w_hit) begin
            r_held <= 1'b0;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = w_hit;
    assign o_key = w_hit ? r_key : '0;

endmodule

>>> design/voice_channel_allocator.sv
// voice channel allocator top level: controller, pitch and velocity mapping,
// the chain of channel cells and the result register
// depends on vca_pkg and vca_cell

// One item is taken at a time. A candidate token walks the chain of channel
// cells, one cell per cycle while the scan is not paused, so the scan of a
// note-on, note-off or cut ends when the token leaves the last cell. A note-on
// then sends its results: the note-on alone, or the note-off of a stolen
// channel and then the note-on. A release sends each earlier match out during
// the scan and its final note-off from the flush state after the scan; a
// release with no match also passes through that state. The block is ready
// again once the final result has moved into the result register. Releases
// come out in channel order, one per matching channel, with last on the final
// one. An unknown kind is taken and dropped. The scan pauses whenever the
// result register is full and stalled.

module voice_channel_allocator import vca_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic [31:0]         i_note_id,
    input  logic [15:0]         i_note_source,
    input  logic signed [15:0]  i_pitch_octaves,
    input  logic [7:0]          i_velocity,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_action,
    output logic [VCA_CH_W-1:0] o_channel,
    output logic [6:0]          o_key,
    output logic signed [18:0]  o_tuning,
    output logic [6:0]          o_strike,
    output logic                o_last
);

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    logic [6:0]          r_note_key;
    logic signed [18:0]  r_tuning;
    logic [6:0]          r_strike;
    logic [31:0]         r_age_ctr;
    t_cand               r_seed;
    t_cand               r_best;
    logic                r_pend_v;
    logic [VCA_CH_W-1:0] r_pend_chan;
    logic [6:0]          r_pend_key;
    logic                n_pend_v;
    logic                r_out_v;
    logic                r_out_action;
    logic [VCA_CH_W-1:0] r_out_chan;
    logic [6:0]          r_out_key;
    logic signed [18:0]  r_out_tuning;
    logic [6:0]          r_out_strike;
    logic                r_out_last;

    logic                w_in_fire;
    logic                w_scan_go;
    logic                w_out_free;
    logic                w_adv;
    logic                w_pend_load;
    logic                w_best_load;
    logic                w_out_load;
    logic                w_out_action;
    logic [VCA_CH_W-1:0] w_out_chan;
    logic [6:0]          w_out_key;
    logic signed [18:0]  w_out_tuning;
    logic [6:0]          w_out_strike;
    logic                w_out_last;
    t_wr                 w_wr;
    logic [6:0]          w_key;
    logic signed [18:0]  w_tuning;
    logic [6:0]          w_strike;

    t_cand               w_tok      [VCA_CHANNELS+1];
    logic                w_cell_hit [VCA_CHANNELS];
    logic [6:0]          w_cell_key [VCA_CHANNELS];
    logic                w_hit;
    logic [6:0]          w_hit_key;
    logic [VCA_CH_W-1:0] w_hit_chan;
    logic [VCA_CHANNELS:0] w_live;

    // input and output handshakes
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_scan_go  = w_in_fire && (i_kind == KIND_ON || i_kind == KIND_OFF
                                      || i_kind == KIND_CUT);
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_adv      = (r_state == ST_SCAN) && w_out_free;

    // pitch to key and tuning: m = 60*4096 + 12*p, key rounds half away from zero
    always_comb begin
        logic signed [20:0] p_ext;
        logic signed [20:0] m;
        logic signed [20:0] m_rnd;
        logic signed [20:0] key_ext;
        p_ext   = 21'(i_pitch_octaves);
        m       = 21'sd245760 + (p_ext <<< 3) + (p_ext <<< 2);
        m_rnd   = m + 21'sd2048;
        if (m < 0) begin
            w_key = '0;
        end else if (m_rnd[20:12] > 9'd127) begin
            w_key = 7'd127;
        end else begin
            w_key = m_rnd[18:12];
        end
        key_ext  = {2'b00, w_key, 12'b0};
        w_tuning = 19'(m - key_ext);
    end

    // velocity floored at 1 and saturated at 127
    always_comb begin
        if (i_velocity > 8'd127) begin
            w_strike = 7'd127;
        end else if (i_velocity == 8'd0) begin
            w_strike = 7'd1;
        end else begin
            w_strike = i_velocity[6:0];
        end
    end

    // chain of channel cells
    assign w_tok[0] = r_seed;

    for (genvar k = 0; k < VCA_CHANNELS; k++) begin : g_cell
        vca_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (VCA_CH_W'(k)),
            .i_adv   (w_adv),
            .i_cmd   (r_cmd),
            .i_tok   (w_tok[k]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[k+1]),
            .o_hit   (w_cell_hit[k]),
            .o_key   (w_cell_key[k])
        );
    end

    // collect the release match of the cell holding the token
    always_comb begin
        w_hit      = 1'b0;
        w_hit_key  = '0;
        w_hit_chan = '0;
        for (int k = 0; k < VCA_CHANNELS; k++) begin
            w_hit     = w_hit | w_cell_hit[k];
            w_hit_key = w_hit_key | w_cell_key[k];
            if (w_cell_hit[k]) begin
                w_hit_chan = w_hit_chan | VCA_CH_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k <= VCA_CHANNELS; k++) begin
            w_live[k] = w_tok[k].live;
        end
    end

    // next state and result selection
    always_comb begin
        n_state      = r_state;
        n_pend_v     = r_pend_v;
        w_pend_load  = 1'b0;
        w_best_load  = 1'b0;
        w_out_load   = 1'b0;
        w_out_action = ACT_OFF;
        w_out_chan   = r_pend_chan;
        w_out_key    = r_pend_key;
        w_out_tuning = '0;
        w_out_strike = '0;
        w_out_last   = 1'b0;
        w_wr         = '0;
        w_wr.idx     = r_best.idx;
        w_wr.id      = r_cmd.id;
        w_wr.src     = r_cmd.src;
        w_wr.key     = r_note_key;
        w_wr.age     = r_age_ctr;
        case (r_state)
            ST_IDLE: begin
                if (w_scan_go) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_adv) begin
                    // a new match pushes the previous one out, not final
                    if (w_hit) begin
                        w_out_load  = r_pend_v;
                        w_pend_load = 1'b1;
                        n_pend_v    = 1'b1;
                    end
                    if (w_tok[VCA_CHANNELS].live) begin
                        if (r_cmd.on) begin
                            w_best_load = 1'b1;
                            n_state = w_tok[VCA_CHANNELS].free ? ST_STRIKE : ST_STEAL;
                        end else begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            ST_STEAL: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_chan = r_best.idx;
                    w_out_key  = r_best.key;
                    n_state    = ST_STRIKE;
                end
            end
            ST_STRIKE: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_out_action = ACT_ON;
                    w_out_chan   = r_best.idx;
                    w_out_key    = r_note_key;
                    w_out_tuning = r_tuning;
                    w_out_strike = r_strike;
                    w_out_last   = 1'b1;
                    w_wr.en      = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command capture on input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd.on    <= (i_kind == KIND_ON);
            r_cmd.by_id <= (i_kind == KIND_OFF);
            r_cmd.id    <= i_note_id;
            r_cmd.src   <= i_note_source;
            r_note_key  <= w_key;
            r_tuning    <= w_tuning;
            r_strike    <= w_strike;
        end
    end

    // seed token entering the first cell, only for kinds that scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_scan_go) begin
            r_seed <= '{live: 1'b1, default: '0};
        end else if (w_adv) begin
            r_seed <= '0;
        end
    end

    // age counter, wraps freely
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_ctr <= '0;
        end else if (w_wr.en) begin
            r_age_ctr <= r_age_ctr + 32'd1;
        end
    end

    // chosen channel and pending release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_best_load) begin
            r_best <= w_tok[VCA_CHANNELS];
        end
        if (w_pend_load) begin
            r_pend_chan <= w_hit_chan;
            r_pend_key  <= w_hit_key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_action <= w_out_action;
            r_out_chan   <= w_out_chan;
            r_out_key    <= w_out_key;
            r_out_tuning <= w_out_tuning;
            r_out_strike <= w_out_strike;
            r_out_last   <= w_out_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_action    = r_out_action;
    assign o_channel   = r_out_chan;
    assign o_key       = r_out_key;
    assign o_tuning    = r_out_tuning;
    assign o_strike    = r_out_strike;
    assign o_last      = r_out_last;

    // at most one token walks the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one live token in the cell chain");

    // no release left pending once the block is ready for the next item
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending release left behind at idle");

    // the age counter moves only with a channel write
    a_age_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_age_ctr != $past(r_age_ctr)) |-> $past(w_wr.en))
        else $error("age counter moved without a note-on");

    // a token only walks while a scan is in progress
    a_scan_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_live != '0) |-> (r_state == ST_SCAN))
        else $error("live token outside a scan");

endmodule
